// File: src/bgtm_pkg.sv
package bgtm_pkg;

    localparam int RAW_W      = 12;
    localparam int MV_W       = 13;
    localparam int PCT_W      = 8;
    localparam int DRIFT_W    = 8;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 13;

    localparam int FRAC_BITS_DEF = 8;

    localparam int PROD_W   = 23;
    localparam int MUL_B_W  = 24;

    localparam logic [MUL_B_W-1:0] SCALE_MUL   = 24'd1534;
    localparam logic [MUL_B_W-1:0] RECIP_1000  = 24'd8589935;
    localparam int                 DIV_SHIFT   = 33;

    localparam int                 EMA_SHIFT   = 16;
    localparam logic [MUL_B_W-1:0] COEF_V_OLD  = 24'd49152;
    localparam logic [MUL_B_W-1:0] COEF_V_NEW  = 24'd16384;
    localparam logic [MUL_B_W-1:0] COEF_F_OLD  = 24'd52428;
    localparam logic [MUL_B_W-1:0] COEF_F_NEW  = 24'd13107;
    localparam logic [MUL_B_W-1:0] COEF_S_OLD  = 24'd62259;
    localparam logic [MUL_B_W-1:0] COEF_S_NEW  = 24'd3276;

    localparam logic [CFG_IDX_W-1:0] CFG_ENABLE    = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_REJECT_LO = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_REJECT_HI = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_FULL      = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_DRIFT     = 3'd4;

    localparam logic [MV_W-1:0]    RST_REJECT_LO = 13'd3000;
    localparam logic [MV_W-1:0]    RST_REJECT_HI = 13'd4400;
    localparam logic [MV_W-1:0]    RST_FULL      = 13'd4150;
    localparam logic [DRIFT_W-1:0] RST_DRIFT     = 8'd3;

    localparam logic [PCT_W-1:0] LEVEL_NONE = 8'hFF;

    // discharge curve, highest voltage first
    localparam int CURVE_POINTS = 10;
    localparam int CPCT_W       = 7;
    localparam int RECIP_W      = 16;
    localparam int LVL_SHIFT    = 20;

    localparam logic [MV_W-1:0] CURVE_MV [CURVE_POINTS] = '{
        13'd4200, 13'd4100, 13'd4000, 13'd3900, 13'd3800,
        13'd3700, 13'd3600, 13'd3500, 13'd3400, 13'd3300};
    localparam logic [CPCT_W-1:0] CURVE_PCT [CURVE_POINTS] = '{
        7'd100, 7'd91, 7'd79, 7'd65, 7'd52, 7'd38, 7'd23, 7'd11, 7'd4, 7'd0};
    // ceil(2^LVL_SHIFT / segment span in mV)
    localparam logic [RECIP_W-1:0] CURVE_RECIP [CURVE_POINTS-1] = '{
        16'd10486, 16'd10486, 16'd10486, 16'd10486, 16'd10486,
        16'd10486, 16'd10486, 16'd10486, 16'd10486};

    typedef struct packed {
        logic issue;
        logic accumulate;
    } mac_ctl_t;

    typedef struct packed {
        logic               above;
        logic               below;
        logic [CPCT_W-1:0]  base_pct;
        logic [CPCT_W-1:0]  pct_step;
        logic [MV_W-1:0]    lo_mv;
        logic [RECIP_W-1:0] recip;
    } seg_t;

endpackage

// File: src/bgtm_mac.sv
module bgtm_mac #(
    parameter int A_W = bgtm_pkg::PROD_W,
    parameter int B_W = bgtm_pkg::MUL_B_W
) (
    input  logic                 aclk,
    input  bgtm_pkg::mac_ctl_t   ctl,
    input  logic [A_W-1:0]       op_a,
    input  logic [B_W-1:0]       op_b,
    output logic [A_W+B_W:0]     acc
);

    logic [A_W+B_W-1:0] prod;
    logic [A_W+B_W:0]   acc_reg;
    logic [A_W+B_W:0]   acc_next;

    assign prod = op_a * op_b;

    always_comb begin
        acc_next = acc_reg;
        if (ctl.issue) begin
            acc_next = (ctl.accumulate ? acc_reg : '0) + {1'b0, prod};
        end
    end

    always_ff @(posedge aclk) begin
        acc_reg <= acc_next;
    end

    assign acc = acc_reg;

endmodule

// File: src/bgtm_curve.sv
module bgtm_curve (
    input  logic [bgtm_pkg::MV_W-1:0] mv,
    output bgtm_pkg::seg_t            seg
);

    always_comb begin
        seg = '0;
        seg.below = 1'b1;
        // lowest index wins: scan upward from the bottom of the curve
        for (int i = bgtm_pkg::CURVE_POINTS - 2; i >= 0; i--) begin
            if (mv >= bgtm_pkg::CURVE_MV[i+1]) begin
                seg.below    = 1'b0;
                seg.lo_mv    = bgtm_pkg::CURVE_MV[i+1];
                seg.base_pct = bgtm_pkg::CURVE_PCT[i+1];
                seg.pct_step = bgtm_pkg::CURVE_PCT[i] - bgtm_pkg::CURVE_PCT[i+1];
                seg.recip    = bgtm_pkg::CURVE_RECIP[i];
            end
        end
        seg.above = (mv >= bgtm_pkg::CURVE_MV[0]);
        if (seg.above) begin
            seg.base_pct = bgtm_pkg::CURVE_PCT[0];
        end
    end

endmodule

// File: src/battery_gauge_trend_monitor.sv
// Channel   Ports                          Word
// input     s_valid / s_ready              s_raw_sample_mv
// result    m_valid / m_ready              m_filtered_mv, m_level_percent, m_charging
// config    cfg_we, cfg_idx, cfg_wdata     write only, no wait
//
// An enabled word steps from ST_DIV through ST_CMP, skipping states it does not need, to
// ST_OUT, and then back to ST_IDLE; a disabled word goes straight to ST_OUT.
// Every multiply goes through the single multiply-accumulate unit, one product a cycle.
// s_ready is high only while the sequencer is idle; a finished result waits in ST_OUT
// until the output register is empty or m_ready is high, then the next word is taken.
// aresetn is synchronous: clears the averages, trend flags and config to defaults.
module battery_gauge_trend_monitor #(
    parameter int FRAC_BITS = bgtm_pkg::FRAC_BITS_DEF
) (
    input  logic                                  aclk,
    input  logic                                  aresetn,
    input  logic                                  s_valid,
    output logic                                  s_ready,
    input  logic [bgtm_pkg::RAW_W-1:0]            s_raw_sample_mv,
    output logic                                  m_valid,
    input  logic                                  m_ready,
    output logic [bgtm_pkg::MV_W-1:0]             m_filtered_mv,
    output logic signed [bgtm_pkg::PCT_W-1:0]     m_level_percent,
    output logic                                  m_charging,
    input  logic                                  cfg_we,
    input  logic [bgtm_pkg::CFG_IDX_W-1:0]        cfg_idx,
    input  logic [bgtm_pkg::CFG_DATA_W-1:0]       cfg_wdata
);

    localparam int MV_W    = bgtm_pkg::MV_W;
    localparam int PCT_W   = bgtm_pkg::PCT_W;
    localparam int EMA_W   = MV_W + FRAC_BITS;
    localparam int MUL_A_W = (EMA_W > bgtm_pkg::PROD_W) ? EMA_W : bgtm_pkg::PROD_W;
    localparam int MUL_B_W = bgtm_pkg::MUL_B_W;
    localparam int ACC_W   = MUL_A_W + MUL_B_W + 1;
    localparam int CPCT_W  = bgtm_pkg::CPCT_W;

    localparam logic [3:0] ST_IDLE = 4'd0;
    localparam logic [3:0] ST_DIV  = 4'd1;
    localparam logic [3:0] ST_WIN  = 4'd2;
    localparam logic [3:0] ST_V1   = 4'd3;
    localparam logic [3:0] ST_V2   = 4'd4;
    localparam logic [3:0] ST_LVL  = 4'd5;
    localparam logic [3:0] ST_LDIV = 4'd6;
    localparam logic [3:0] ST_LSUM = 4'd7;
    localparam logic [3:0] ST_TRD  = 4'd8;
    localparam logic [3:0] ST_F1   = 4'd9;
    localparam logic [3:0] ST_S0   = 4'd10;
    localparam logic [3:0] ST_S1   = 4'd11;
    localparam logic [3:0] ST_CMP  = 4'd12;
    localparam logic [3:0] ST_OUT  = 4'd13;

    logic [3:0]                 state_reg, state_next;

    logic                       enable_reg;
    logic [MV_W-1:0]            rej_lo_reg, rej_hi_reg, full_reg;
    logic [bgtm_pkg::DRIFT_W-1:0] drift_reg;

    logic [EMA_W-1:0]           ema_reg, ema_next;
    logic [EMA_W-1:0]           fast_reg, fast_next;
    logic [EMA_W-1:0]           slow_reg, slow_next;
    logic                       seeded_reg, seeded_next;
    logic                       chg_state_reg, chg_state_next;

    logic [MV_W-1:0]            scaled_reg, scaled_next;
    logic [MV_W-1:0]            res_mv_reg, res_mv_next;
    logic [PCT_W-1:0]           res_level_reg, res_level_next;
    logic                       res_chg_reg, res_chg_next;

    logic                       m_valid_reg, m_valid_next;
    logic [MV_W-1:0]            m_mv_reg;
    logic [PCT_W-1:0]           m_level_reg;
    logic                       m_chg_reg;
    logic                       out_load;

    bgtm_pkg::mac_ctl_t         mac_ctl;
    logic [MUL_A_W-1:0]         mac_a;
    logic [MUL_B_W-1:0]         mac_b;
    logic [ACC_W-1:0]           acc;

    bgtm_pkg::seg_t             seg;

    logic [MV_W-1:0]            scaled_w;
    logic                       in_win;
    logic [MV_W-1:0]            mv_w;
    logic [EMA_W-1:0]           m_fix;
    logic [EMA_W-1:0]           mix_w;
    logic [EMA_W-1:0]           band;
    logic [CPCT_W-1:0]          lvl_q;
    logic                       rise, fall;

    bgtm_mac #(
        .A_W (MUL_A_W),
        .B_W (MUL_B_W)
    ) u_mac (
        .aclk (aclk),
        .ctl  (mac_ctl),
        .op_a (mac_a),
        .op_b (mac_b),
        .acc  (acc)
    );

    bgtm_curve u_curve (
        .mv  (mv_w),
        .seg (seg)
    );

    assign scaled_w = acc[bgtm_pkg::DIV_SHIFT +: MV_W];
    assign in_win   = (scaled_w >= rej_lo_reg) && (scaled_w <= rej_hi_reg);
    assign mv_w     = ema_reg[FRAC_BITS +: MV_W];
    assign m_fix    = EMA_W'(mv_w) << FRAC_BITS;
    assign mix_w    = acc[bgtm_pkg::EMA_SHIFT +: EMA_W];
    assign band     = EMA_W'(drift_reg) << FRAC_BITS;
    assign lvl_q    = acc[bgtm_pkg::LVL_SHIFT +: CPCT_W];
    // mix_w holds the new slow average in ST_CMP
    assign rise     = (fast_reg >= mix_w) && ((fast_reg - mix_w) >= band);
    assign fall     = (mix_w >= fast_reg) && ((mix_w - fast_reg) >= band);

    assign s_ready  = (state_reg == ST_IDLE);
    assign out_load = (state_reg == ST_OUT) && (!m_valid_reg || m_ready);

    always_comb begin
        state_next     = state_reg;
        ema_next       = ema_reg;
        fast_next      = fast_reg;
        slow_next      = slow_reg;
        seeded_next    = seeded_reg;
        chg_state_next = chg_state_reg;
        scaled_next    = scaled_reg;
        res_mv_next    = res_mv_reg;
        res_level_next = res_level_reg;
        res_chg_next   = res_chg_reg;
        mac_ctl        = '0;
        mac_a          = '0;
        mac_b          = '0;

        unique case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    if (!enable_reg) begin
                        res_mv_next    = '0;
                        res_level_next = bgtm_pkg::LEVEL_NONE;
                        res_chg_next   = 1'b0;
                        state_next     = ST_OUT;
                    end else begin
                        mac_ctl.issue = 1'b1;
                        mac_a         = MUL_A_W'(s_raw_sample_mv);
                        mac_b         = bgtm_pkg::SCALE_MUL;
                        state_next    = ST_DIV;
                    end
                end
            end
            ST_DIV: begin
                // divide by 1000 via reciprocal
                mac_ctl.issue = 1'b1;
                mac_a         = MUL_A_W'(acc[bgtm_pkg::PROD_W-1:0]);
                mac_b         = bgtm_pkg::RECIP_1000;
                state_next    = ST_WIN;
            end
            ST_WIN: begin
                scaled_next = scaled_w;
                state_next  = ST_LVL;
                if (in_win) begin
                    if (mv_w == '0) begin
                        ema_next = EMA_W'(scaled_w) << FRAC_BITS;
                    end else begin
                        mac_ctl.issue = 1'b1;
                        mac_a         = MUL_A_W'(ema_reg);
                        mac_b         = bgtm_pkg::COEF_V_OLD;
                        state_next    = ST_V1;
                    end
                end
            end
            ST_V1: begin
                mac_ctl.issue      = 1'b1;
                mac_ctl.accumulate = 1'b1;
                mac_a              = MUL_A_W'(EMA_W'(scaled_reg) << FRAC_BITS);
                mac_b              = bgtm_pkg::COEF_V_NEW;
                state_next         = ST_V2;
            end
            ST_V2: begin
                ema_next   = mix_w;
                state_next = ST_LVL;
            end
            ST_LVL: begin
                res_mv_next = mv_w;
                if (mv_w == '0) begin
                    res_level_next = bgtm_pkg::LEVEL_NONE;
                    res_chg_next   = chg_state_reg;
                    state_next     = ST_OUT;
                end else if (seg.above || seg.below) begin
                    res_level_next = PCT_W'(seg.base_pct);
                    state_next     = ST_TRD;
                end else begin
                    mac_ctl.issue = 1'b1;
                    mac_a         = MUL_A_W'(mv_w - seg.lo_mv);
                    mac_b         = MUL_B_W'(seg.pct_step);
                    state_next    = ST_LDIV;
                end
            end
            ST_LDIV: begin
                mac_ctl.issue = 1'b1;
                mac_a         = MUL_A_W'(acc[MUL_A_W-1:0]);
                mac_b         = MUL_B_W'(seg.recip);
                state_next    = ST_LSUM;
            end
            ST_LSUM: begin
                res_level_next = PCT_W'(seg.base_pct) + PCT_W'(lvl_q);
                state_next     = ST_TRD;
            end
            ST_TRD: begin
                if (!seeded_reg) begin
                    fast_next    = m_fix;
                    slow_next    = m_fix;
                    seeded_next  = 1'b1;
                    res_chg_next = 1'b0;
                    state_next   = ST_OUT;
                end else begin
                    mac_ctl.issue = 1'b1;
                    mac_a         = MUL_A_W'(fast_reg);
                    mac_b         = bgtm_pkg::COEF_F_OLD;
                    state_next    = ST_F1;
                end
            end
            ST_F1: begin
                mac_ctl.issue      = 1'b1;
                mac_ctl.accumulate = 1'b1;
                mac_a              = MUL_A_W'(m_fix);
                mac_b              = bgtm_pkg::COEF_F_NEW;
                state_next         = ST_S0;
            end
            ST_S0: begin
                fast_next     = mix_w;
                mac_ctl.issue = 1'b1;
                mac_a         = MUL_A_W'(slow_reg);
                mac_b         = bgtm_pkg::COEF_S_OLD;
                state_next    = ST_S1;
            end
            ST_S1: begin
                mac_ctl.issue      = 1'b1;
                mac_ctl.accumulate = 1'b1;
                mac_a              = MUL_A_W'(m_fix);
                mac_b              = bgtm_pkg::COEF_S_NEW;
                state_next         = ST_CMP;
            end
            ST_CMP: begin
                slow_next = mix_w;
                priority if (mv_w >= full_reg) begin
                    chg_state_next = 1'b1;
                end else if (rise) begin
                    chg_state_next = 1'b1;
                end else if (fall) begin
                    chg_state_next = 1'b0;
                end else begin
                    chg_state_next = chg_state_reg;
                end
                res_chg_next = chg_state_next;
                state_next   = ST_OUT;
            end
            ST_OUT: begin
                if (out_load) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb begin
        m_valid_next = m_valid_reg;
        if (out_load) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            ema_reg       <= '0;
            fast_reg      <= '0;
            slow_reg      <= '0;
            seeded_reg    <= 1'b0;
            chg_state_reg <= 1'b0;
            m_valid_reg   <= 1'b0;
        end else begin
            state_reg     <= state_next;
            ema_reg       <= ema_next;
            fast_reg      <= fast_next;
            slow_reg      <= slow_next;
            seeded_reg    <= seeded_next;
            chg_state_reg <= chg_state_next;
            m_valid_reg   <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        scaled_reg    <= scaled_next;
        res_mv_reg    <= res_mv_next;
        res_level_reg <= res_level_next;
        res_chg_reg   <= res_chg_next;
        if (out_load) begin
            m_mv_reg    <= res_mv_reg;
            m_level_reg <= res_level_reg;
            m_chg_reg   <= res_chg_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            enable_reg <= 1'b0;
            rej_lo_reg <= bgtm_pkg::RST_REJECT_LO;
            rej_hi_reg <= bgtm_pkg::RST_REJECT_HI;
            full_reg   <= bgtm_pkg::RST_FULL;
            drift_reg  <= bgtm_pkg::RST_DRIFT;
        end else if (cfg_we) begin
            unique case (cfg_idx)
                bgtm_pkg::CFG_ENABLE:    enable_reg <= cfg_wdata[0];
                bgtm_pkg::CFG_REJECT_LO: rej_lo_reg <= cfg_wdata[MV_W-1:0];
                bgtm_pkg::CFG_REJECT_HI: rej_hi_reg <= cfg_wdata[MV_W-1:0];
                bgtm_pkg::CFG_FULL:      full_reg   <= cfg_wdata[MV_W-1:0];
                bgtm_pkg::CFG_DRIFT:     drift_reg  <= cfg_wdata[bgtm_pkg::DRIFT_W-1:0];
                default: begin
                end
            endcase
        end
    end

    assign m_valid         = m_valid_reg;
    assign m_filtered_mv   = m_mv_reg;
    assign m_level_percent = $signed(m_level_reg);
    assign m_charging      = m_chg_reg;

endmodule

// File: src/bgtm_checker.sv
module bgtm_checker (
    input logic                                  aclk,
    input logic                                  aresetn,
    input logic                                  s_valid,
    input logic                                  s_ready,
    input logic                                  m_valid,
    input logic                                  m_ready,
    input logic [bgtm_pkg::MV_W-1:0]             m_filtered_mv,
    input logic signed [bgtm_pkg::PCT_W-1:0]     m_level_percent,
    input logic                                  m_charging
);

    a_reset_clears_out: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result valid after reset");

    a_busy_after_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready)
        else $error("input taken while word in progress");

    a_level_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_level_percent == -8'sd1) ||
                    (m_level_percent >= 8'sd0 && m_level_percent <= 8'sd100))
        else $error("level out of range");

    a_level_none_iff_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> ((m_level_percent == -8'sd1) == (m_filtered_mv == '0)))
        else $error("level and filtered mV disagree");

    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_filtered_mv) &&
                                $stable(m_level_percent) && $stable(m_charging))
        else $error("stalled result changed");

endmodule

bind battery_gauge_trend_monitor bgtm_checker u_bgtm_checker (.*);

// File: bench/battery_gauge_trend_monitor_tb.sv
module battery_gauge_trend_monitor_tb;

    localparam int FB           = 8;
    localparam int LIMIT_CYCLES = 400000;
    localparam int RANDOM_WORDS = 1500;
    localparam int IDLE_PCT     = 22;

    localparam logic [63:0] K_V_OLD = 64'd49152;
    localparam logic [63:0] K_V_NEW = 64'd16384;
    localparam logic [63:0] K_F_OLD = 64'd52428;
    localparam logic [63:0] K_F_NEW = 64'd13107;
    localparam logic [63:0] K_S_OLD = 64'd62259;
    localparam logic [63:0] K_S_NEW = 64'd3276;

    typedef struct packed {
        logic [bgtm_pkg::MV_W-1:0]         mv;
        logic signed [bgtm_pkg::PCT_W-1:0] level;
        logic                              chg;
    } gauge_word_t;

    typedef enum logic {ROW_WORD, ROW_REG} row_op_t;

    typedef struct {
        row_op_t                         op;
        logic [bgtm_pkg::CFG_IDX_W-1:0]  idx;
        logic [bgtm_pkg::CFG_DATA_W-1:0] val;
        bit                              exact;
        gauge_word_t                     want;
    } plan_row_t;

    localparam gauge_word_t NO_READING = '{13'd0, -8'sd1, 1'b0};

    logic                              aclk = 1'b0;
    logic                              aresetn;
    logic                              s_valid;
    logic                              s_ready;
    logic [bgtm_pkg::RAW_W-1:0]        s_raw_sample_mv;
    logic                              m_valid;
    logic                              m_ready;
    logic [bgtm_pkg::MV_W-1:0]         m_filtered_mv;
    logic signed [bgtm_pkg::PCT_W-1:0] m_level_percent;
    logic                              m_charging;
    logic                              cfg_we;
    logic [bgtm_pkg::CFG_IDX_W-1:0]    cfg_idx;
    logic [bgtm_pkg::CFG_DATA_W-1:0]   cfg_wdata;

    // predictor state and register copy
    logic [63:0]       volt_acc  = '0;
    logic [63:0]       fast_acc  = '0;
    logic [63:0]       slow_acc  = '0;
    bit                trend_live = 1'b0;
    bit                chg_latch  = 1'b0;
    bit                en_cfg     = 1'b0;
    logic [bgtm_pkg::MV_W-1:0]    lo_cfg    = 13'd3000;
    logic [bgtm_pkg::MV_W-1:0]    hi_cfg    = 13'd4400;
    logic [bgtm_pkg::MV_W-1:0]    full_cfg  = 13'd4150;
    logic [bgtm_pkg::DRIFT_W-1:0] drift_cfg = 8'd3;

    gauge_word_t due_readings[$];
    plan_row_t   plan[$];

    bit calm = 1'b0;
    int errors = 0;
    int words_sent = 0;
    int readings_checked = 0;
    int reg_writes = 0;
    int charging_seen = 0;
    int nolevel_seen = 0;
    int full_pct_seen = 0;
    int empty_pct_seen = 0;
    int cycles = 0;

    battery_gauge_trend_monitor #(.FRAC_BITS(FB)) dut (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_raw_sample_mv (s_raw_sample_mv),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_filtered_mv   (m_filtered_mv),
        .m_level_percent (m_level_percent),
        .m_charging      (m_charging),
        .cfg_we          (cfg_we),
        .cfg_idx         (cfg_idx),
        .cfg_wdata       (cfg_wdata)
    );

    always #6 aclk = ~aclk;

    function automatic logic [63:0] ema_blend(input logic [63:0] prev, input logic [63:0] smp,
                                              input logic [63:0] k_old,
                                              input logic [63:0] k_new);
        return (prev * k_old + smp * k_new) >> 16;
    endfunction

    function automatic int unsigned knee_mv(input int i);
        return 4200 - 100 * i;
    endfunction

    function automatic int unsigned knee_pct(input int i);
        case (i)
            0: return 100;
            1: return 91;
            2: return 79;
            3: return 65;
            4: return 52;
            5: return 38;
            6: return 23;
            7: return 11;
            8: return 4;
            default: return 0;
        endcase
    endfunction

    function automatic logic signed [bgtm_pkg::PCT_W-1:0] soc_percent(input int unsigned mv);
        int unsigned hi, lo, span_mv, pct_step;
        if (mv == 0) return -8'sd1;
        for (int i = 0; i + 1 < 10; i++) begin
            hi = knee_mv(i);
            lo = knee_mv(i + 1);
            if (mv >= hi) return 8'(knee_pct(i));
            if (mv >= lo) begin
                span_mv  = hi - lo;
                pct_step = knee_pct(i) - knee_pct(i + 1);
                return 8'(knee_pct(i + 1) + (mv - lo) * pct_step / span_mv);
            end
        end
        return 8'sd0;
    endfunction

    function automatic gauge_word_t gauge_predict(input logic [bgtm_pkg::RAW_W-1:0] raw);
        gauge_word_t r;
        logic [63:0] scaled, fixed_mv, band;
        int unsigned mv;
        bit chg;
        r = NO_READING;
        if (!en_cfg) return r;
        scaled = 64'(raw) * 64'd1534 / 64'd1000;
        if (scaled >= 64'(lo_cfg) && scaled <= 64'(hi_cfg)) begin
            if (volt_acc < (64'd1 << FB))
                volt_acc = scaled << FB;
            else
                volt_acc = ema_blend(volt_acc, scaled << FB, K_V_OLD, K_V_NEW);
        end
        mv = 32'(volt_acc >> FB);
        if (mv == 0) begin
            chg = chg_latch;
        end else if (!trend_live) begin
            fast_acc   = 64'(mv) << FB;
            slow_acc   = fast_acc;
            trend_live = 1'b1;
            chg        = 1'b0;
        end else begin
            fixed_mv = 64'(mv) << FB;
            band     = 64'(drift_cfg) << FB;
            fast_acc = ema_blend(fast_acc, fixed_mv, K_F_OLD, K_F_NEW);
            slow_acc = ema_blend(slow_acc, fixed_mv, K_S_OLD, K_S_NEW);
            if (mv >= full_cfg)
                chg_latch = 1'b1;
            else if (fast_acc >= slow_acc && fast_acc - slow_acc >= band)
                chg_latch = 1'b1;
            else if (slow_acc >= fast_acc && slow_acc - fast_acc >= band)
                chg_latch = 1'b0;
            chg = chg_latch;
        end
        r.mv    = 13'(mv);
        r.level = soc_percent(mv);
        r.chg   = chg;
        return r;
    endfunction

    function automatic plan_row_t word_row(input int raw);
        return '{ROW_WORD, bgtm_pkg::CFG_ENABLE, 13'(raw), 1'b0, NO_READING};
    endfunction

    function automatic plan_row_t exact_row(input int raw, input gauge_word_t want);
        return '{ROW_WORD, bgtm_pkg::CFG_ENABLE, 13'(raw), 1'b1, want};
    endfunction

    function automatic plan_row_t reg_row(input logic [bgtm_pkg::CFG_IDX_W-1:0] idx,
                                          input int val);
        return '{ROW_REG, idx, 13'(val), 1'b0, NO_READING};
    endfunction

    task automatic drain();
        s_valid <= 1'b0;
        cfg_we  <= 1'b0;
        while (due_readings.size() != 0) @(posedge aclk);
        repeat (4) @(posedge aclk);
    endtask

    task automatic cfg_write(input logic [bgtm_pkg::CFG_IDX_W-1:0] idx,
                             input logic [bgtm_pkg::CFG_DATA_W-1:0] val);
        cfg_we    <= 1'b1;
        cfg_idx   <= idx;
        cfg_wdata <= val;
        @(posedge aclk);
        case (idx)
            bgtm_pkg::CFG_ENABLE:    en_cfg    = val[0];
            bgtm_pkg::CFG_REJECT_LO: lo_cfg    = val;
            bgtm_pkg::CFG_REJECT_HI: hi_cfg    = val;
            bgtm_pkg::CFG_FULL:      full_cfg  = val;
            bgtm_pkg::CFG_DRIFT:     drift_cfg = val[bgtm_pkg::DRIFT_W-1:0];
            default: ;
        endcase
        reg_writes++;
    endtask

    task automatic send_word(input logic [bgtm_pkg::RAW_W-1:0] raw, input bit exact,
                             input gauge_word_t want);
        gauge_word_t predicted;
        cfg_we <= 1'b0;
        while (!calm && $urandom_range(99) < IDLE_PCT) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid         <= 1'b1;
        s_raw_sample_mv <= raw;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        predicted = gauge_predict(raw);
        due_readings.push_back(exact ? want : predicted);
        words_sent++;
    endtask

    always @(posedge aclk) begin
        m_ready <= calm ? 1'b1 : ($urandom_range(99) >= IDLE_PCT);
    end

    always @(posedge aclk) begin
        gauge_word_t want;
        if (aresetn && m_valid && m_ready) begin
            if (due_readings.size() == 0) begin
                errors++;
                $display("%0t: unexpected word mv=%0d pct=%0d chg=%0b", $time,
                         m_filtered_mv, m_level_percent, m_charging);
            end else begin
                want = due_readings.pop_front();
                readings_checked++;
                if (m_filtered_mv !== want.mv) begin
                    errors++;
                    $display("%0t: filtered_mv expected %0d got %0d", $time,
                             want.mv, m_filtered_mv);
                end
                if (m_level_percent !== want.level) begin
                    errors++;
                    $display("%0t: level_percent expected %0d got %0d", $time,
                             want.level, m_level_percent);
                end
                if (m_charging !== want.chg) begin
                    errors++;
                    $display("%0t: charging expected %0b got %0b", $time,
                             want.chg, m_charging);
                end
                if (m_charging === 1'b1) charging_seen++;
                if (m_level_percent == -8'sd1) nolevel_seen++;
                if (m_level_percent == 8'sd100) full_pct_seen++;
                if (m_level_percent == 8'sd0) empty_pct_seen++;
            end
        end
    end

    always @(posedge aclk) begin
        cycles++;
        if (cycles > LIMIT_CYCLES) begin
            $display("%0t: timeout, %0d words still due", $time, due_readings.size());
            $display("Some tests failed");
            $finish;
        end
    end

    initial begin
        int rand_words;
        int phase;
        int n_items;
        int mode;
        int base_raw;
        int dir;
        int p;
        int raw;

        aresetn         <= 1'b0;
        s_valid         <= 1'b0;
        s_raw_sample_mv <= '0;
        m_ready         <= 1'b0;
        cfg_we          <= 1'b0;
        cfg_idx         <= '0;
        cfg_wdata       <= '0;
        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // disabled after reset
        plan.push_back(exact_row(0, NO_READING));
        plan.push_back(exact_row(4095, NO_READING));
        plan.push_back(reg_row(bgtm_pkg::CFG_ENABLE, 1));
        // outside default window, nothing filtered yet
        plan.push_back(exact_row(0, NO_READING));
        plan.push_back(exact_row(4095, NO_READING));
        // first accepted sample seeds average and trend
        plan.push_back(exact_row(2700, '{13'd4141, 8'sd94, 1'b0}));
        plan.push_back(word_row(2900));
        plan.push_back(word_row(2868));
        plan.push_back(word_row(1956));
        plan.push_back(word_row(1955));
        plan.push_back(word_row(2869));
        plan.push_back(word_row(2738));
        plan.push_back(word_row(2868));
        plan.push_back(word_row(2868));
        plan.push_back(reg_row(bgtm_pkg::CFG_FULL, 8191));
        plan.push_back(word_row(1956));
        plan.push_back(word_row(1956));
        plan.push_back(reg_row(bgtm_pkg::CFG_DRIFT, 0));
        plan.push_back(word_row(1956));
        plan.push_back(word_row(1956));
        plan.push_back(reg_row(bgtm_pkg::CFG_DRIFT, 255));
        // inverted window rejects everything
        plan.push_back(reg_row(bgtm_pkg::CFG_REJECT_LO, 8191));
        plan.push_back(reg_row(bgtm_pkg::CFG_REJECT_HI, 0));
        plan.push_back(word_row(2500));
        plan.push_back(reg_row(bgtm_pkg::CFG_REJECT_LO, 0));
        plan.push_back(reg_row(bgtm_pkg::CFG_REJECT_HI, 8191));
        plan.push_back(word_row(0));
        plan.push_back(word_row(4095));
        plan.push_back(word_row(1000));
        plan.push_back(word_row(1000));
        plan.push_back(reg_row(bgtm_pkg::CFG_ENABLE, 0));
        plan.push_back(exact_row(1234, NO_READING));
        plan.push_back(reg_row(bgtm_pkg::CFG_ENABLE, 1));
        plan.push_back(reg_row(bgtm_pkg::CFG_FULL, 0));
        plan.push_back(word_row(2100));

        foreach (plan[i]) begin
            if (plan[i].op == ROW_REG) begin
                drain();
                cfg_write(plan[i].idx, plan[i].val);
            end else begin
                send_word(plan[i].val[bgtm_pkg::RAW_W-1:0], plan[i].exact, plan[i].want);
            end
        end

        rand_words = 0;
        phase = 0;
        while (rand_words < RANDOM_WORDS) begin
            drain();
            calm = (phase >= 4 && phase < 7);
            mode = $urandom_range(0, 9);
            cfg_write(bgtm_pkg::CFG_ENABLE, ($urandom_range(0, 9) == 0) ? 13'd0 : 13'd1);
            case (mode)
                0: begin
                    cfg_write(bgtm_pkg::CFG_REJECT_LO, 13'd8191);
                    cfg_write(bgtm_pkg::CFG_REJECT_HI, 13'd0);
                end
                1: begin
                    cfg_write(bgtm_pkg::CFG_REJECT_LO, 13'd0);
                    cfg_write(bgtm_pkg::CFG_REJECT_HI, 13'd8191);
                end
                2: begin
                    // lets near-zero samples in so the average decays below 1 mV
                    cfg_write(bgtm_pkg::CFG_REJECT_LO, 13'd0);
                    cfg_write(bgtm_pkg::CFG_REJECT_HI, 13'($urandom_range(0, 150)));
                end
                3: begin
                    cfg_write(bgtm_pkg::CFG_REJECT_LO, 13'd8191);
                    cfg_write(bgtm_pkg::CFG_REJECT_HI, 13'd8191);
                end
                default: begin
                    cfg_write(bgtm_pkg::CFG_REJECT_LO, 13'($urandom_range(2800, 3300)));
                    cfg_write(bgtm_pkg::CFG_REJECT_HI, 13'($urandom_range(4100, 4600)));
                end
            endcase
            case ($urandom_range(0, 5))
                0: cfg_write(bgtm_pkg::CFG_FULL, 13'd0);
                1: cfg_write(bgtm_pkg::CFG_FULL, 13'd8191);
                default: cfg_write(bgtm_pkg::CFG_FULL, 13'($urandom_range(3900, 4300)));
            endcase
            case ($urandom_range(0, 5))
                0: cfg_write(bgtm_pkg::CFG_DRIFT, 13'd0);
                1: cfg_write(bgtm_pkg::CFG_DRIFT, 13'd255);
                default: cfg_write(bgtm_pkg::CFG_DRIFT, 13'($urandom_range(0, 12)));
            endcase

            n_items  = $urandom_range(40, 80);
            base_raw = $urandom_range(2100, 2800);
            dir      = $urandom_range(0, 2) - 1;
            for (int k = 0; k < n_items; k++) begin
                p = $urandom_range(0, 99);
                if (mode == 2) begin
                    raw = (p < 75) ? 0 : $urandom_range(0, 4095);
                end else if (p < 12) begin
                    raw = $urandom_range(0, 4095);
                end else if (p < 15) begin
                    raw = $urandom_range(0, 1) ? 4095 : 0;
                end else begin
                    raw = base_raw + $urandom_range(0, 8) - 4;
                    base_raw += dir * $urandom_range(0, 6);
                    if (base_raw > 2860) dir = -1;
                    if (base_raw < 2000) dir = 1;
                    if ($urandom_range(0, 19) == 0) dir = $urandom_range(0, 2) - 1;
                end
                send_word(12'(raw), 1'b0, NO_READING);
                rand_words++;
            end
            phase++;
        end

        s_valid <= 1'b0;
        while (due_readings.size() != 0) @(posedge aclk);
        repeat (40) @(posedge aclk);

        $display("Ran %0d sample words over %0d phases, %0d register writes, %0d words checked.",
                 words_sent, phase, reg_writes, readings_checked);
        $display("Seen: %0d charging, %0d without level, %0d at 100 pct, %0d at 0 pct.",
                 charging_seen, nolevel_seen, full_pct_seen, empty_pct_seen);
        if (errors == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule
